// File: rtl/ssp_pkg.sv
package ssp_pkg;

  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int T_W      = FRAC_W + 1;
  localparam int WFRAC    = 24;
  localparam int WGT_W    = WFRAC + 2;
  localparam int H_W      = 3 * T_W + 1;
  localparam int PROD_W   = COORD_W + WGT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int VAL_W    = ACC_W - WFRAC;
  localparam int NUM_TAPS = 4;
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_LINEAR  = 2'd1,
    ACT_BEZIER  = 2'd2,
    ACT_HERMITE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_PASS,
    KIND_LINEAR,
    KIND_BEZIER,
    KIND_HERMITE
  } kind_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;

  typedef struct packed {
    action_e          action;
    logic             last_key;
    logic [T_W-1:0]   param_t;
    coord_t           start_point;
    coord_t           start_in_handle;
    coord_t           start_out_handle;
    coord_t           end_point;
    coord_t           end_in_handle;
    coord_t           end_out_handle;
  } in_item_t;

  typedef struct packed {
    coord_t curve_value;
    logic   saturated;
  } out_item_t;

  // one blend job: sum(pt * wgt) with weights in Q.24
  typedef struct packed {
    coord_t [NUM_TAPS-1:0] pt;
    wgt_t   [NUM_TAPS-1:0] wgt;
  } job_t;

endpackage

// File: rtl/ssp_front.sv
module ssp_front import ssp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  // stage 0: clamp, classify, pick points
  logic [T_W-1:0]         t_clamp;
  kind_e                  kind;
  coord_t [NUM_TAPS-1:0]  pt_sel;

  always_comb begin
    t_clamp = (item_i.param_t > T_ONE) ? T_ONE : item_i.param_t;
    if (item_i.last_key) begin
      kind = KIND_PASS;
    end else begin
      case (item_i.action)
        ACT_LINEAR:  kind = KIND_LINEAR;
        ACT_BEZIER:  kind = KIND_BEZIER;
        ACT_HERMITE: kind = KIND_HERMITE;
        default:     kind = KIND_ZERO;
      endcase
    end
    pt_sel[0] = item_i.start_point;
    case (kind)
      KIND_BEZIER: begin
        pt_sel[1] = item_i.start_out_handle;
        pt_sel[2] = item_i.end_in_handle;
        pt_sel[3] = item_i.end_point;
      end
      KIND_HERMITE: begin
        pt_sel[1] = item_i.end_point;
        pt_sel[2] = item_i.start_in_handle;
        pt_sel[3] = item_i.end_out_handle;
      end
      default: begin
        pt_sel[1] = item_i.end_point;
        pt_sel[2] = '0;
        pt_sel[3] = '0;
      end
    endcase
  end

  logic                   s0_valid_q, s1_valid_q, s2_valid_q, job_valid_q;
  kind_e                  s0_kind_q, s1_kind_q, s2_kind_q;
  coord_t [NUM_TAPS-1:0]  s0_pt_q, s1_pt_q, s2_pt_q;
  logic [T_W-1:0]         s0_t_q, s0_u_q, s1_t_q, s1_u_q, s2_t_q, s2_u_q;
  logic [2*T_W-1:0]       s1_t2_q, s1_u2_q, s2_t2_q;
  logic [3*T_W-1:0]       s2_t3_q, s2_u3_q, s2_tu2_q, s2_t2u_q;
  job_t                   job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= accept_i;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      job_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_kind_q <= kind;
    s0_pt_q   <= pt_sel;
    s0_t_q    <= t_clamp;
    s0_u_q    <= T_ONE - t_clamp;

    s1_kind_q <= s0_kind_q;
    s1_pt_q   <= s0_pt_q;
    s1_t_q    <= s0_t_q;
    s1_u_q    <= s0_u_q;
    s1_t2_q   <= s0_t_q * s0_t_q;
    s1_u2_q   <= s0_u_q * s0_u_q;

    s2_kind_q <= s1_kind_q;
    s2_pt_q   <= s1_pt_q;
    s2_t_q    <= s1_t_q;
    s2_u_q    <= s1_u_q;
    s2_t2_q   <= s1_t2_q;
    s2_t3_q   <= s1_t2_q * s1_t_q;
    s2_u3_q   <= s1_u2_q * s1_u_q;
    s2_tu2_q  <= s1_u2_q * s1_t_q;
    s2_t2u_q  <= s1_t2_q * s1_u_q;
  end

  // weight in units of 2^-48 to Q.24, round half up
  function automatic wgt_t wround(input logic [H_W-1:0] h);
    logic [H_W-1:0] r;
    r = h + (H_W'(1) << (WFRAC - 1));
    return r[WFRAC +: WGT_W];
  endfunction

  logic [H_W-1:0]        t3h, u3h, tu2h, t2uh, t2s, t2s3, ts, one48;
  wgt_t [NUM_TAPS-1:0]   wgt;

  always_comb begin
    t3h   = H_W'(s2_t3_q);
    u3h   = H_W'(s2_u3_q);
    tu2h  = H_W'(s2_tu2_q);
    t2uh  = H_W'(s2_t2u_q);
    t2s   = H_W'({s2_t2_q, FRAC_W'(0)});
    t2s3  = (t2s << 1) + t2s;
    ts    = H_W'({s2_t_q, (2 * FRAC_W)'(0)});
    one48 = H_W'(1) << (3 * FRAC_W);
    wgt   = '0;
    case (s2_kind_q)
      KIND_PASS: begin
        wgt[0] = WGT_W'(1) << WFRAC;
      end
      KIND_LINEAR: begin
        wgt[0] = WGT_W'({s2_u_q, (WFRAC - FRAC_W)'(0)});
        wgt[1] = WGT_W'({s2_t_q, (WFRAC - FRAC_W)'(0)});
      end
      KIND_BEZIER: begin
        wgt[0] = wround(u3h);
        wgt[1] = wround((tu2h << 1) + tu2h);
        wgt[2] = wround((t2uh << 1) + t2uh);
        wgt[3] = wround(t3h);
      end
      KIND_HERMITE: begin
        wgt[0] = wround((t3h << 1) - t2s3 + one48);
        wgt[1] = wround(t2s3 - (t3h << 1));
        wgt[2] = wround(t3h - (t2s << 1) + ts);
        wgt[3] = wround(t3h - t2s);
      end
      default: begin
        wgt = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q.pt  <= s2_pt_q;
    job_q.wgt <= wgt;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// File: rtl/ssp_job_queue.sv
module ssp_job_queue import ssp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic alloc_i,
  output logic full_o,
  input  logic wr_i,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  output job_t rd_job_o,
  input  logic take_i
);

  // credits cover words inside the front pipeline as well as stored ones
  logic [QCNT_W-1:0] credit_q, credit_d;
  logic [QCNT_W-1:0] stored_q, stored_d;
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  job_t              mem_q [QDEPTH];

  always_comb begin
    credit_d = credit_q + QCNT_W'(alloc_i) - QCNT_W'(take_i);
    stored_d = stored_q + QCNT_W'(wr_i) - QCNT_W'(take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      stored_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      credit_q <= credit_d;
      stored_q <= stored_d;
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (take_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  assign full_o     = (credit_q == QCNT_W'(QDEPTH));
  assign rd_valid_o = (stored_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> (stored_q != '0))
    else $error("job taken from empty queue");

  a_stored_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= credit_q)
    else $error("stored jobs exceed allocated credits");
`endif

endmodule

// File: rtl/ssp_back.sv
module ssp_back import ssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      take_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic [QCNT_W-1:0] credit_q, credit_d;
  logic [QCNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic [QPTR_W-1:0] oq_wr_q, oq_rd_q;
  out_item_t         oq_mem_q [QDEPTH];
  logic              popped;
  logic              a_valid_q, b_valid_q;
  logic signed [PROD_W-1:0] prod_d [NUM_TAPS];
  logic signed [PROD_W-1:0] prod_q [NUM_TAPS];
  logic signed [ACC_W-1:0]  s01_q, s23_q, total;
  logic signed [VAL_W-1:0]  val;
  out_item_t                res;

  // credits cover the multiply/add stages plus the output queue
  assign take_o = job_valid_i && (credit_q != QCNT_W'(QDEPTH));
  assign popped = pop_i && (oq_cnt_q != '0);

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      prod_d[i] = $signed(job_i.pt[i]) * $signed(job_i.wgt[i]);
    end
  end

  always_comb begin
    total = s01_q + s23_q;
    val   = total[ACC_W-1:WFRAC];
    if (val[VAL_W-1:COORD_W-1] == '0 || val[VAL_W-1:COORD_W-1] == '1) begin
      res.curve_value = val[COORD_W-1:0];
      res.saturated   = 1'b0;
    end else begin
      res.curve_value = val[VAL_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
      res.saturated   = 1'b1;
    end
  end

  always_comb begin
    credit_d = credit_q + QCNT_W'(take_o) - QCNT_W'(popped);
    oq_cnt_d = oq_cnt_q + QCNT_W'(b_valid_q) - QCNT_W'(popped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      credit_q  <= '0;
      oq_cnt_q  <= '0;
      oq_wr_q   <= '0;
      oq_rd_q   <= '0;
    end else begin
      a_valid_q <= take_o;
      b_valid_q <= a_valid_q;
      credit_q  <= credit_d;
      oq_cnt_q  <= oq_cnt_d;
      if (b_valid_q) begin
        oq_wr_q <= oq_wr_q + QPTR_W'(1);
      end
      if (popped) begin
        oq_rd_q <= oq_rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    // rounding constant folded into the first partial sum
    s01_q  <= ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + (ACC_W'(1) <<< (WFRAC - 1));
    s23_q  <= ACC_W'(prod_q[2]) + ACC_W'(prod_q[3]);
    if (b_valid_q) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  assign empty_o    = (oq_cnt_q == '0);
  assign out_item_o = oq_mem_q[oq_rd_q];

`ifndef NO_ASSERTIONS
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (oq_cnt_q != QCNT_W'(QDEPTH)))
    else $error("result written into full output queue");

  a_oq_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= credit_q)
    else $error("output queue holds more than its credits");
`endif

endmodule

// File: rtl/spline_segment_point_evaluator_unit.sv
// channel  | ports                       | accepted when
// ---------+-----------------------------+----------------------
// input    | push, full, in_item_i       | push & !full
// result   | empty, pop, out_item_o      | pop & !empty
//
// One word accepted and one result delivered per cycle, sustained, while full and empty stay low.
// A word accepted passes, when nothing stalls, through 4 front stages (clamp, squares,
// cubes, weight rounding), a job queue slot, 2 multiply/add stages and the output
// queue write before it can be popped from the result ports.
// full rises once 8 words sit in the weight pipeline and job queue;
// empty stays low while the 8-entry output queue holds results.
// Reset clears all valid bits, counters and pointers; no clearing pass.
module spline_segment_point_evaluator_unit import ssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic job_valid;
  job_t job;
  logic q_valid;
  job_t q_job;
  logic take;

  assign accept = push && !full;

  ssp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  ssp_job_queue u_job_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alloc_i    (accept),
    .full_o     (full),
    .wr_i       (job_valid),
    .wr_job_i   (job),
    .rd_valid_o (q_valid),
    .rd_job_o   (q_job),
    .take_i     (take)
  );

  ssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .take_o      (take),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssp_pkg::*;

  localparam int     N_RANDOM    = 1580;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     MAX_REPORTS = 200;
  localparam int     DRAIN_WAIT  = 24;
  localparam longint T_UNIT      = longint'(1) << FRAC_W;
  localparam coord_t COORD_MAX   = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN   = 32'sh8000_0000;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i     = 1'b1;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  out_item_t pending_vals[$];
  dir_row_t  dir_tab[$];
  int        n_sent     = 0;
  int        n_err      = 0;
  int        burst_left = 0;
  int        cyc        = 0;

  spline_segment_point_evaluator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // weight in 2^-48 units -> Q.24, round half up
  function automatic longint round_wgt(longint h);
    return (h + (longint'(1) << 23)) >>> WFRAC;
  endfunction

  function automatic out_item_t eval_curve(in_item_t w);
    longint    t, u, t2, t3, acc;
    longint    pt[NUM_TAPS];
    longint    wt[NUM_TAPS];
    out_item_t r;
    r = '0;
    t = longint'(w.param_t);
    if (t > T_UNIT) t = T_UNIT;
    if (w.last_key) begin
      r.curve_value = w.start_point;
    end else if (w.action != ACT_NONE) begin
      u  = T_UNIT - t;
      t2 = t * t;
      t3 = t2 * t;
      for (int i = 0; i < NUM_TAPS; i++) begin
        pt[i] = 0;
        wt[i] = 0;
      end
      case (w.action)
        ACT_LINEAR: begin
          pt[0] = w.start_point; wt[0] = round_wgt(u << 32);
          pt[1] = w.end_point;   wt[1] = round_wgt(t << 32);
        end
        ACT_BEZIER: begin
          pt[0] = w.start_point;      wt[0] = round_wgt(u * u * u);
          pt[1] = w.start_out_handle; wt[1] = round_wgt(3 * t * u * u);
          pt[2] = w.end_in_handle;    wt[2] = round_wgt(3 * t2 * u);
          pt[3] = w.end_point;        wt[3] = round_wgt(t3);
        end
        default: begin
          pt[0] = w.start_point;
          wt[0] = round_wgt(2 * t3 - 3 * (t2 << 16) + (longint'(1) << 48));
          pt[1] = w.end_point;
          wt[1] = round_wgt(-2 * t3 + 3 * (t2 << 16));
          pt[2] = w.start_in_handle;
          wt[2] = round_wgt(t3 - 2 * (t2 << 16) + (t << 32));
          pt[3] = w.end_out_handle;
          wt[3] = round_wgt(t3 - (t2 << 16));
        end
      endcase
      acc = 0;
      for (int i = 0; i < NUM_TAPS; i++) acc += pt[i] * wt[i];
      acc = (acc + (longint'(1) << 23)) >>> WFRAC;
      if (acc > longint'(COORD_MAX)) begin
        acc = COORD_MAX;
        r.saturated = 1'b1;
      end else if (acc < longint'(COORD_MIN)) begin
        acc = COORD_MIN;
        r.saturated = 1'b1;
      end
      r.curve_value = acc[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic in_item_t mk(action_e a, bit lk, int unsigned t, coord_t sp, coord_t si,
                                  coord_t so, coord_t ep, coord_t ei, coord_t eo);
    in_item_t w;
    w.action           = a;
    w.last_key         = lk;
    w.param_t          = t[T_W-1:0];
    w.start_point      = sp;
    w.start_in_handle  = si;
    w.start_out_handle = so;
    w.end_point        = ep;
    w.end_in_handle    = ei;
    w.end_out_handle   = eo;
    return w;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3, 4, 5: return coord_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_word();
    int unsigned t;
    case ($urandom_range(0, 9))
      0:       t = 0;
      1:       t = 32'(T_UNIT);
      2, 3:    t = $urandom_range(0, (1 << T_W) - 1);
      default: t = $urandom_range(0, 32'(T_UNIT));
    endcase
    return mk(action_e'($urandom_range(0, 3)), $urandom_range(0, 9) == 0, t,
              rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic void add_row(in_item_t w, bit typed, out_item_t want);
    dir_row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = want;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // offer one word, wait for it to be taken, then maybe idle before the next
  task automatic offer(in_item_t w, out_item_t want);
    int gap;
    push      <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (full !== 1'b0);
    pending_vals.insert(pending_vals.size(), want);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    in_item_t w;
    add_row(mk(ACT_HERMITE, 1, 32768, 32'sh1234_5678, COORD_MAX, COORD_MIN, 1, 2, 3),
            1, '{32'sh1234_5678, 1'b0});
    add_row(mk(ACT_NONE, 1, 0, COORD_MIN, 5, 6, 7, 8, 9), 1, '{COORD_MIN, 1'b0});
    add_row(mk(ACT_BEZIER, 1, 32'h1FFFF, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
               COORD_MIN, COORD_MIN), 1, '{COORD_MAX, 1'b0});
    add_row(mk(ACT_NONE, 0, 32768, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX), 1, '{'0, 1'b0});
    add_row(mk(ACT_NONE, 0, 32'h1FFFF, -1, -1, -1, -1, -1, -1), 1, '{'0, 1'b0});
    add_row(mk(ACT_LINEAR, 0, 0, 32'sh0001_0000, 0, 0, 32'shFFFF_0000, 0, 0),
            1, '{32'sh0001_0000, 1'b0});
    add_row(mk(ACT_LINEAR, 0, 32'(T_UNIT), 32'sh0001_0000, 0, 0, 32'shFFFF_0000, 0, 0),
            1, '{32'shFFFF_0000, 1'b0});
    // t above one clamps to one
    add_row(mk(ACT_LINEAR, 0, 32'h1FFFF, COORD_MIN, 0, 0, COORD_MAX, 0, 0),
            1, '{COORD_MAX, 1'b0});
    add_row(mk(ACT_LINEAR, 0, 32768, COORD_MAX, 0, 0, COORD_MAX, 0, 0), 1, '{COORD_MAX, 1'b0});
    add_row(mk(ACT_LINEAR, 0, 32768, COORD_MIN, 0, 0, COORD_MIN, 0, 0), 1, '{COORD_MIN, 1'b0});
    add_row(mk(ACT_BEZIER, 0, 0, 32'sh0BAD_F00D, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
               COORD_MIN), 1, '{32'sh0BAD_F00D, 1'b0});
    add_row(mk(ACT_BEZIER, 0, 32'(T_UNIT), 32'sh0BAD_F00D, COORD_MAX, COORD_MAX, -7,
               COORD_MIN, COORD_MIN), 1, '{-7, 1'b0});
    add_row(mk(ACT_HERMITE, 0, 0, -12345, COORD_MAX, COORD_MAX, 99, COORD_MAX, COORD_MAX),
            1, '{-12345, 1'b0});
    add_row(mk(ACT_HERMITE, 0, 32'(T_UNIT), -12345, COORD_MAX, COORD_MAX, 99, COORD_MAX,
               COORD_MAX), 1, '{99, 1'b0});
    add_row(mk(ACT_HERMITE, 0, 32768, COORD_MAX, COORD_MAX, 0, COORD_MAX, 0, 0),
            1, '{COORD_MAX, 1'b1});
    add_row(mk(ACT_HERMITE, 0, 32768, COORD_MIN, COORD_MIN, 0, COORD_MIN, 0, 0),
            1, '{COORD_MIN, 1'b1});
    add_row(mk(ACT_BEZIER, 0, 32768, COORD_MAX, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0),
            1, '{COORD_MAX, 1'b0});
    add_row(mk(ACT_LINEAR, 0, 1, COORD_MAX, 0, 0, COORD_MIN, 0, 0), 0, '0);
    add_row(mk(ACT_BEZIER, 0, 12345, 32'sh0003_8000, 0, -32'sh0002_0000, 32'sh0010_0000,
               32'sh7000_0000, 0), 0, '0);
    add_row(mk(ACT_HERMITE, 0, 40000, 32'sh0001_2345, COORD_MAX, COORD_MIN, -32'sh0004_0000,
               COORD_MIN, COORD_MAX), 0, '0);
    add_row(mk(ACT_HERMITE, 0, 32'h10001, 32'sh0001_0000, 32'sh0100_0000, 0, 32'sh0002_0000,
               0, -32'sh0100_0000), 0, '0);
    add_row(mk(ACT_BEZIER, 0, 65535, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
               COORD_MAX), 0, '0);
    add_row(mk(ACT_HERMITE, 0, 21845, 0, COORD_MAX, 0, 0, 0, COORD_MIN), 0, '0);

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_tab[i])
      offer(dir_tab[i].word, dir_tab[i].typed ? dir_tab[i].want : eval_curve(dir_tab[i].word));
    for (int i = 0; i < N_RANDOM; i++) begin
      w = rand_word();
      offer(w, eval_curve(w));
    end
    push <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: check each word taken, then pick the next pop
  initial begin : drain
    out_item_t exp_v;
    int        mode;
    int        rx_cyc;
    int        hold_left;
    int        hold_mark;
    mode      = 0;
    rx_cyc    = 0;
    hold_left = 0;
    hold_mark = 200;
    forever begin
      @(posedge clk_i);
      if (pop && empty === 1'b0) begin
        if (pending_vals.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, got %h/%b", $time,
                     out_item_o.curve_value, out_item_o.saturated);
        end else begin
          exp_v = pending_vals.pop_front();
          if (out_item_o.curve_value !== exp_v.curve_value) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
              $display("%0t: curve_value mismatch: expected %h, got %h", $time,
                       exp_v.curve_value, out_item_o.curve_value);
          end
          if (out_item_o.saturated !== exp_v.saturated) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
              $display("%0t: saturated mismatch: expected %b, got %b", $time,
                       exp_v.saturated, out_item_o.saturated);
          end
        end
      end
      rx_cyc++;
      if (rx_cyc % 64 == 0) mode = $urandom_range(0, 3);
      // long hold-off while the sender keeps pushing, so the unit backs up
      if (hold_mark > 0 && n_sent >= hold_mark) begin
        hold_left = $urandom_range(150, 250);
        hold_mark = (hold_mark == 200) ? 1000 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= $urandom_range(0, 1);
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= rx_cyc[3];
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
